// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Default screen geometry and tab stop spacing
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 24;
    localparam int DEF_TAB_WIDTH = 4;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = 11;
    localparam int DATA_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    // Packed stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Control character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // One result item
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
    } t_result;

endpackage

// ===== hdl/tcw_in_stage.sv =====
// Input register stage holding one accepted character.
`timescale 1ns / 1ps

module tcw_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tcw_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic                        i_take,
    output logic                        o_valid,
    output logic [tcw_pkg::CHAR_W-1:0]  o_char
);
    import tcw_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [CHAR_W-1:0] r_char;
    logic              w_load;

    // Free when empty or when the held character moves on this cycle
    assign s_axis_tready = !r_valid || i_take;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the character on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= s_axis_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

// ===== hdl/tcw_cursor.sv =====
// Cursor state and per-character cell write decode.
`timescale 1ns / 1ps

module tcw_cursor #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_attr,
    output tcw_pkg::t_result            o_result
);
    import tcw_pkg::*;

    localparam int TW_EFF      = (TAB_WIDTH < 1) ? 1 : TAB_WIDTH;
    localparam int PHASE_W     = (TW_EFF > 1) ? $clog2(TW_EFF) : 1;
    localparam int SUM_W       = COL_W + 1;
    localparam int CELL_W      = ADDR_W + 1;

    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TW_EFF - 1);
    localparam logic [PHASE_W-1:0] PHASE_EOL  = PHASE_W'((COLUMNS - 1) % TW_EFF);
    localparam logic [SUM_W-1:0]   TAB_STEP   = SUM_W'(TW_EFF);
    localparam logic [SUM_W-1:0]   COL_LIMIT  = SUM_W'(COLUMNS);
    localparam logic [CELL_W-1:0]  ROW_PITCH  = CELL_W'(COLUMNS);

    logic [COL_W-1:0]   r_col,   n_col;
    logic [ROW_W-1:0]   r_row,   n_row;
    // Column position modulo the tab spacing, kept alongside the column
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic [ROW_W-1:0]   w_row_inc;
    logic [SUM_W-1:0]   w_tab_sum;
    logic               w_we;
    logic               w_use_new;
    logic [COL_W-1:0]   w_cell_col;
    logic [ROW_W-1:0]   w_cell_row;
    logic [CELL_W-1:0]  w_cell;
    logic [DATA_W-1:0]  w_data;

    // Row after a line feed, wrapping past the last row
    assign w_row_inc = (r_row >= ROW_LAST) ? '0 : r_row + ROW_W'(1);
    assign w_tab_sum = SUM_W'(r_col) + TAB_STEP - SUM_W'(r_phase);

    // Decode the character into the next cursor position and the cell write
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_phase   = r_phase;
        w_we      = 1'b0;
        w_use_new = 1'b0;
        w_data    = {i_attr, i_char};
        unique case (i_char)
            CH_NEWLINE: begin
                n_col   = '0;
                n_row   = w_row_inc;
                n_phase = '0;
            end
            CH_BACKSPACE: begin
                w_we      = 1'b1;
                w_use_new = 1'b1;
                w_data    = {i_attr, CH_SPACE};
                if (r_col == '0) begin
                    if (r_row != '0) begin
                        n_col   = COL_LAST;
                        n_row   = r_row - ROW_W'(1);
                        n_phase = PHASE_EOL;
                    end
                end else begin
                    n_col   = r_col - COL_W'(1);
                    n_phase = (r_phase == '0) ? PHASE_LAST : r_phase - PHASE_W'(1);
                end
            end
            CH_TAB: begin
                n_phase = '0;
                if (w_tab_sum >= COL_LIMIT) begin
                    n_col = '0;
                    n_row = w_row_inc;
                end else begin
                    n_col = w_tab_sum[COL_W-1:0];
                end
            end
            CH_RETURN: begin
                n_col   = '0;
                n_phase = '0;
            end
            default: begin
                w_we = 1'b1;
                if (r_col >= COL_LAST) begin
                    n_col   = '0;
                    n_row   = w_row_inc;
                    n_phase = '0;
                end else begin
                    n_col   = r_col + COL_W'(1);
                    n_phase = (r_phase >= PHASE_LAST) ? '0 : r_phase + PHASE_W'(1);
                end
            end
        endcase
    end

    // Cell index: backspace blanks the new position, printables the old one
    assign w_cell_col = w_use_new ? n_col : r_col;
    assign w_cell_row = w_use_new ? n_row : r_row;
    assign w_cell     = CELL_W'(w_cell_col) + CELL_W'(w_cell_row) * ROW_PITCH;

    always_comb begin
        o_result.write_enable  = w_we;
        o_result.write_address = w_we ? w_cell[ADDR_W-1:0] : '0;
        o_result.write_data    = w_we ? w_data : '0;
        o_result.cursor_column = n_col;
        o_result.cursor_row    = n_row;
    end

    // Advance the cursor on each character handled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_step) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("cursor column beyond last column");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_LAST)
        else $error("cursor row beyond last row");

    a_quiet_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.write_enable |->
            (o_result.write_address == '0 && o_result.write_data == '0))
        else $error("address or data set without a cell write");

    a_newline_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_char == CH_NEWLINE) |=> (r_col == '0 && r_phase == '0))
        else $error("newline did not return the cursor to column zero");

endmodule

// ===== hdl/tcw_out_stage.sv =====
// Result register stage driving the master-side stream.
`timescale 1ns / 1ps

module tcw_out_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  tcw_pkg::t_result                i_result,
    output logic                            o_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [10:0] write_address,
                                                           // [26:11] write_data,
                                                           // [33:27] cursor_column,
                                                           // [38:34] cursor_row, [39] zero
    output logic                            m_axis_tuser   // [0] write_enable
);
    import tcw_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    w_load;

    // Take a new result when empty or when the held one leaves
    assign o_free = !r_valid || m_axis_tready;
    assign w_load = i_valid && o_free;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the result until its transaction completes
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_result.write_enable;
    assign m_axis_tdata  = {1'b0, r_result.cursor_row, r_result.cursor_column,
                            r_result.write_data, r_result.write_address};

endmodule

// ===== hdl/text_console_char_writer.sv =====
// Path: an accepted character is loaded into the input register, then into the result
// register once the result stage is free; the result register presents the result.
// Throughput: one character per cycle while the output stream is not stalled; the cursor update
// is one pass of logic between the input register and the result register.
// Reset (synchronous, active low): cursor to column 0, row 0, attribute to 0x0F,
// both stages empty.
`timescale 1ns / 1ps

module text_console_char_writer #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] char_code
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [10:0] write_address,
                                                           // [26:11] write_data,
                                                           // [33:27] cursor_column,
                                                           // [38:34] cursor_row, [39] zero
    output logic                            m_axis_tuser,  // [0] write_enable
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]      i_cfg_data     // text_attribute
);
    import tcw_pkg::*;

    logic              r_attr;
    logic [ATTR_W-1:0] r_attr_q;
    logic              w_in_valid;
    logic [CHAR_W-1:0] w_in_char;
    logic              w_out_free;
    logic              w_step;
    t_result           w_result;

    // Attribute register, written by each configuration transaction
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_q <= ATTR_RESET;
            r_attr   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr_q <= i_cfg_data;
            r_attr   <= 1'b1;
        end
    end

    // Move one character from the input register into the result register
    assign w_step = w_in_valid && w_out_free;

    tcw_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_take        (w_step),
        .o_valid       (w_in_valid),
        .o_char        (w_in_char)
    );

    tcw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_char   (w_in_char),
        .i_attr   (r_attr_q),
        .o_result (w_result)
    );

    tcw_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_in_valid),
        .i_result      (w_result),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> m_axis_tvalid)
        else $error("handled character produced no result");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_out_free) |=> w_in_valid)
        else $error("character dropped while the result stage was full");

    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_attr && r_attr_q == $past(i_cfg_data)))
        else $error("attribute write not taken");

endmodule
